FILE: hdl/assert_macros.svh
// Assertion macros shared by the stepper position follower RTL.
// Each macro wraps a clocked concurrent assertion that is masked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk while rst is low.
`define SPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a property in the following cycle.
`define SPF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: hdl/spf_pkg.sv
// Types and constants for the stepper position follower.
// Self-contained; used by stepper_position_follower_core.
package spf_pkg;

  // Motion modes carried in command bits 31:30.
  typedef enum logic [1:0] {
    MODE_MOVE = 2'd0,
    MODE_DOWN = 2'd1,
    MODE_UP   = 2'd2,
    MODE_OFF  = 2'd3
  } mode_t;

  localparam int unsigned CmdWidth    = 32;
  localparam int unsigned TargetWidth = 30;
  localparam int unsigned PosWidth    = 32;
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 40;

  // Result fields, readback in the lowest bits.
  typedef struct packed {
    logic                moving;
    logic                driver_enable;
    logic                direction_line;
    logic                step_line;
    logic [PosWidth-1:0] readback;
  } result_t;

  localparam int unsigned ResultWidth = $bits(result_t);

endpackage

FILE: hdl/stepper_position_follower_core.sv
// Stepper position follower: command writes and step ticks in, status out.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while m_axis_tready does not stall the output,
// set by the single compare-and-step path between the two registers.
// Reset (rst, synchronous, active high) empties both registers and clears
// mode, target, position, motion, driver enable and the step/direction levels.
`include "assert_macros.svh"

module stepper_position_follower_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] command, [32] top_stop, [33] bottom_stop
  input  logic [spf_pkg::InDataWidth-1:0]  s_axis_tdata,
  input  logic                             s_axis_tuser,   // [0] func (0 = command write, 1 = tick)
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] readback, [32] step_line, [33] direction_line, [34] driver_enable,
  // [35] moving
  output logic [spf_pkg::OutDataWidth-1:0] m_axis_tdata
);

  // Input register.
  logic                            in_valid;
  logic                            in_func;
  logic [spf_pkg::CmdWidth-1:0]    in_cmd;
  logic                            in_top;
  logic                            in_bottom;

  // Controller state.
  spf_pkg::mode_t                  mode, mode_next;
  logic [spf_pkg::TargetWidth-1:0] target, target_next;
  logic [spf_pkg::PosWidth-1:0]    position, position_next;
  logic                            active, active_next;
  logic                            enabled, enabled_next;
  logic                            step_level, step_level_next;
  logic                            dir_level, dir_level_next;

  // Result register.
  logic                            out_valid;
  spf_pkg::result_t                result, result_next;

  logic                            advance;
  logic                            do_up;
  logic                            do_down;
  logic [spf_pkg::PosWidth-1:0]    target_ext;

  // An item moves into the result register whenever that register frees up.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(spf_pkg::OutDataWidth - spf_pkg::ResultWidth)'(0), result};
  assign target_ext    = {2'b00, target};

  // Next state for the item held in the input register.
  always_comb begin
    mode_next       = mode;
    target_next     = target;
    position_next   = position;
    active_next     = active;
    enabled_next    = enabled;
    step_level_next = step_level;
    dir_level_next  = dir_level;
    do_up           = 1'b0;
    do_down         = 1'b0;

    if (!in_func) begin
      mode_next   = spf_pkg::mode_t'(in_cmd[31:30]);
      target_next = in_cmd[spf_pkg::TargetWidth-1:0];
      if (mode_next == spf_pkg::MODE_OFF) begin
        active_next  = 1'b0;
        enabled_next = 1'b0;
      end else begin
        active_next  = 1'b1;
        enabled_next = 1'b1;
      end
    end else if (active) begin
      unique case (mode)
        spf_pkg::MODE_UP:   do_up   = 1'b1;
        spf_pkg::MODE_DOWN: do_down = 1'b1;
        spf_pkg::MODE_MOVE, spf_pkg::MODE_OFF: begin
          // A negative position always lies below the target.
          if (!position[spf_pkg::PosWidth-1] && (target_ext < position)) begin
            do_down = 1'b1;
          end else if (position[spf_pkg::PosWidth-1] || (target_ext > position)) begin
            do_up = 1'b1;
          end else begin
            active_next = 1'b0;
          end
        end
        default: active_next = active;
      endcase
    end

    // One step up, or stop on the top switch.
    if (do_up) begin
      if (!in_top) begin
        position_next   = position + spf_pkg::PosWidth'(1);
        dir_level_next  = 1'b1;
        step_level_next = !step_level;
      end else begin
        active_next = 1'b0;
      end
    end

    // One step down, or stop on the bottom switch and zero the position.
    if (do_down) begin
      if (!in_bottom) begin
        position_next   = position - spf_pkg::PosWidth'(1);
        dir_level_next  = 1'b0;
        step_level_next = !step_level;
      end else begin
        position_next = '0;
        active_next   = 1'b0;
      end
    end

    result_next.readback       = position_next |
                                 {in_top, in_bottom, (spf_pkg::PosWidth - 2)'(0)};
    result_next.step_line      = step_level_next;
    result_next.direction_line = dir_level_next;
    result_next.driver_enable  = enabled_next;
    result_next.moving         = active_next;
  end

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_func   <= s_axis_tuser;
      in_cmd    <= s_axis_tdata[31:0];
      in_top    <= s_axis_tdata[32];
      in_bottom <= s_axis_tdata[33];
    end
  end

  // State update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= spf_pkg::MODE_MOVE;
      target     <= '0;
      position   <= '0;
      active     <= 1'b0;
      enabled    <= 1'b0;
      step_level <= 1'b0;
      dir_level  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        mode       <= mode_next;
        target     <= target_next;
        position   <= position_next;
        active     <= active_next;
        enabled    <= enabled_next;
        step_level <= step_level_next;
        dir_level  <= dir_level_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      result <= result_next;
    end
  end

  // The motor can only be moving while the driver is on.
  `SPF_ASSERT(a_active_needs_enable, !active || enabled, "motion active with driver off")
  // State changes only when an item passes to the result register.
  `SPF_ASSERT_NEXT(a_state_holds, !advance,
    $stable(position) && $stable(active) && $stable(step_level),
    "controller state changed without an item")
  // A command write never steps the motor.
  `SPF_ASSERT_NEXT(a_command_no_step, advance && !in_func,
    $stable(position) && $stable(step_level) && $stable(dir_level),
    "command write moved the motor")
  // The shown motion flag tracks the stored state.
  `SPF_ASSERT(a_moving_matches, !out_valid || (result.moving == active),
    "moving flag differs from controller state")

endmodule
